>>> rtl/core/jbcr_pkg.sv
// ----------------------------------------------------------------------------
// jbcr_pkg
// Shared types, command codes and response tables for the joybus responder.
// ----------------------------------------------------------------------------
package jbcr_pkg;

    // command bytes sent by the console
    localparam logic [7:0] CMD_PROBE      = 8'h00;
    localparam logic [7:0] CMD_POLL       = 8'h40;
    localparam logic [7:0] CMD_ORIGIN     = 8'h41;
    localparam logic [7:0] CMD_ORIGIN_EXT = 8'h42;
    localparam logic [7:0] CMD_LINK_RESET = 8'h1D;

    // byte counter codes
    localparam logic [4:0] IDLE_CODE      = 5'd31;
    localparam logic [4:0] CNT_SHORT      = 5'd1;
    localparam logic [4:0] CNT_LINK_RESET = 5'd9;

    // power-on analog mode
    localparam logic [7:0] MODE_RESET = 8'h03;

    // word selector values
    localparam logic SEL_LINK_BYTE  = 1'b0;
    localparam logic SEL_REPORT_UPD = 1'b1;
    localparam logic KIND_TX_BYTE   = 1'b0;
    localparam logic KIND_LINK_RST  = 1'b1;

    // kind of response run
    typedef enum logic [1:0] {
        RESP_PROBE  = 2'd0,
        RESP_ORIGIN = 2'd1,
        RESP_POLL   = 2'd2,
        RESP_RESET  = 2'd3
    } resp_kind_t;

    // everything needed to emit one response run
    typedef struct packed {
        resp_kind_t      kind;
        logic [7:0][7:0] report;
        logic            rumble;
        logic            brake;
        logic [7:0]      mode;
    } resp_desc_t;

    // pending slot handed from decoder to sequencer
    typedef struct packed {
        logic       valid;
        resp_desc_t desc;
    } resp_slot_t;

    // number of words in a run
    function automatic logic [3:0] resp_len(resp_kind_t kind);
        logic [3:0] len;
        case (kind)
            RESP_PROBE:  len = 4'd3;
            RESP_ORIGIN: len = 4'd10;
            RESP_POLL:   len = 4'd8;
            RESP_RESET:  len = 4'd1;
            default:     len = 4'd1;
        endcase
        return len;
    endfunction

    // probe answer: device id and status
    function automatic logic [7:0] probe_byte(logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h09;
            4'd1:    b = 8'h00;
            4'd2:    b = 8'h03;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // origin answer: centered sticks, triggers released
    function automatic logic [7:0] origin_byte(logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5: b = 8'h80;
            default:                      b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/core/jbcr_cmd_decode.sv
// ----------------------------------------------------------------------------
// jbcr_cmd_decode
// Command state, report store and one-entry pending response register.
// ----------------------------------------------------------------------------
module jbcr_cmd_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                sel,
    input  logic [7:0]          rx_byte,
    input  logic [7:0][7:0]     report_in,
    input  logic                load,
    output jbcr_pkg::resp_slot_t pend
);

    logic [4:0]      remain_reg, remain_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [7:0]      mode_reg, mode_next;
    logic            rumble_reg, rumble_next;
    logic            brake_reg, brake_next;
    logic [7:0][7:0] store_reg, store_next;
    logic            pvalid_reg, pvalid_next;
    jbcr_pkg::resp_desc_t pdesc_reg, pdesc_next;

    logic                 has_resp;
    jbcr_pkg::resp_kind_t resp_kind;

    // command sequencing for one accepted word
    always_comb
    begin
        remain_next = remain_reg;
        cmd_next    = cmd_reg;
        mode_next   = mode_reg;
        rumble_next = rumble_reg;
        brake_next  = brake_reg;
        store_next  = store_reg;
        has_resp    = 1'b0;
        resp_kind   = jbcr_pkg::RESP_PROBE;
        if (accept)
        begin
            if (sel == jbcr_pkg::SEL_REPORT_UPD)
            begin
                store_next = report_in;
            end
            else if (remain_reg == jbcr_pkg::IDLE_CODE)
            begin
                cmd_next = rx_byte;
                if (rx_byte == jbcr_pkg::CMD_PROBE)
                begin
                    has_resp  = 1'b1;
                    resp_kind = jbcr_pkg::RESP_PROBE;
                end
                else if (rx_byte == jbcr_pkg::CMD_ORIGIN)
                begin
                    has_resp  = 1'b1;
                    resp_kind = jbcr_pkg::RESP_ORIGIN;
                end
                else if (rx_byte == jbcr_pkg::CMD_LINK_RESET)
                begin
                    remain_next = jbcr_pkg::CNT_LINK_RESET;
                end
                else
                begin
                    remain_next = jbcr_pkg::CNT_SHORT;
                end
            end
            else if (remain_reg == 5'd0)
            begin
                remain_next = jbcr_pkg::IDLE_CODE;
                case (cmd_reg)
                    jbcr_pkg::CMD_LINK_RESET:
                    begin
                        has_resp  = 1'b1;
                        resp_kind = jbcr_pkg::RESP_RESET;
                    end
                    jbcr_pkg::CMD_POLL:
                    begin
                        rumble_next = rx_byte[0];
                        brake_next  = rx_byte[1];
                        has_resp    = 1'b1;
                        resp_kind   = jbcr_pkg::RESP_POLL;
                    end
                    jbcr_pkg::CMD_ORIGIN_EXT:
                    begin
                        has_resp  = 1'b1;
                        resp_kind = jbcr_pkg::RESP_ORIGIN;
                    end
                    default:
                    begin
                        has_resp = 1'b0;
                    end
                endcase
            end
            else
            begin
                // first poll data byte carries the analog mode
                if (remain_reg == 5'd1 && cmd_reg == jbcr_pkg::CMD_POLL)
                begin
                    mode_next = rx_byte;
                end
                remain_next = remain_reg - 5'd1;
            end
        end
    end

    // pending slot: filled by a word with a response, emptied on load
    always_comb
    begin
        pdesc_next = pdesc_reg;
        if (has_resp)
        begin
            pvalid_next       = 1'b1;
            pdesc_next.kind   = resp_kind;
            pdesc_next.report = store_reg;
            pdesc_next.rumble = rumble_next;
            pdesc_next.brake  = brake_next;
            pdesc_next.mode   = mode_next;
        end
        else if (load)
        begin
            pvalid_next = 1'b0;
        end
        else
        begin
            pvalid_next = pvalid_reg;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= jbcr_pkg::IDLE_CODE;
            cmd_reg    <= jbcr_pkg::CMD_PROBE;
            mode_reg   <= jbcr_pkg::MODE_RESET;
            rumble_reg <= 1'b0;
            brake_reg  <= 1'b0;
            store_reg  <= '0;
            pvalid_reg <= 1'b0;
        end
        else
        begin
            remain_reg <= remain_next;
            cmd_reg    <= cmd_next;
            mode_reg   <= mode_next;
            rumble_reg <= rumble_next;
            brake_reg  <= brake_next;
            store_reg  <= store_next;
            pvalid_reg <= pvalid_next;
        end
    end

    // pending payload
    always_ff @(posedge clk)
    begin
        pdesc_reg <= pdesc_next;
    end

    assign pend.valid = pvalid_reg;
    assign pend.desc  = pdesc_reg;

endmodule

>>> rtl/core/jbcr_tx_seq.sv
// ----------------------------------------------------------------------------
// jbcr_tx_seq
// Output sequencer: emits one response run word by word.
// ----------------------------------------------------------------------------
module jbcr_tx_seq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  jbcr_pkg::resp_slot_t pend,
    output logic                 load,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    logic                 act_valid_reg, act_valid_next;
    jbcr_pkg::resp_desc_t act_reg, act_next;
    logic [3:0]           idx_reg, idx_next;
    logic                 is_last;
    logic                 take;
    logic [7:0]           tx_byte;

    assign is_last = (idx_reg == jbcr_pkg::resp_len(act_reg.kind) - 4'd1);
    assign take    = act_valid_reg && m_tready;
    assign load    = !act_valid_reg || (take && is_last);

    // advance through the run, pick up the pending run when done
    always_comb
    begin
        act_valid_next = act_valid_reg;
        act_next       = act_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            act_valid_next = pend.valid;
            act_next       = pend.desc;
            idx_next       = 4'd0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    // byte for the current position
    always_comb
    begin
        case (act_reg.kind)
            jbcr_pkg::RESP_PROBE:  tx_byte = jbcr_pkg::probe_byte(idx_reg);
            jbcr_pkg::RESP_ORIGIN: tx_byte = jbcr_pkg::origin_byte(idx_reg);
            jbcr_pkg::RESP_POLL:   tx_byte = act_reg.report[idx_reg[2:0]];
            jbcr_pkg::RESP_RESET:  tx_byte = 8'h00;
            default:               tx_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else
        begin
            act_valid_reg <= act_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
    end

    assign m_tvalid = act_valid_reg;
    assign m_tuser  = (act_reg.kind == jbcr_pkg::RESP_RESET) ? jbcr_pkg::KIND_LINK_RST
                                                             : jbcr_pkg::KIND_TX_BYTE;
    assign m_tlast  = is_last;
    assign m_tdata  = {6'd0, act_reg.mode, act_reg.brake, act_reg.rumble, tx_byte};

endmodule

>>> rtl/core/joybus_controller_responder_top.sv
// ----------------------------------------------------------------------------
// joybus_controller_responder_top
// Controller side of a joybus link: command decode and response sequencing.
// ----------------------------------------------------------------------------
// One input word is taken per cycle while s_tready is high. A word that
// triggers a response is parked in a one-entry pending register. The output
// sequencer then drains the run at one result word per cycle while the
// receiver is ready (probe 3, origin 10, poll 8, link reset 1 words). When the
// sequencer is idle, a triggering word is registered in the pending register
// and then loaded into the sequencer's active register, from which the first
// word of the run is offered. Input stalls only while the pending register is
// full, and it resumes in the cycle in which the final word of the active run
// is accepted. Report updates and intermediate command bytes give no response.
// ----------------------------------------------------------------------------
module joybus_controller_responder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // rx_byte, buttons_low, buttons_high, left_stick_x, left_stick_y,
    // right_stick_x, right_stick_y, trigger_left, trigger_right
    input  logic [71:0] s_tdata,
    // link byte or report update select
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_byte, rumble_on, brake_on, report_mode, zero pad
    output logic [23:0] m_tdata,
    // kind
    output logic        m_tuser,
    output logic        m_tlast
);

    jbcr_pkg::resp_slot_t pend;
    logic                 load;
    logic                 accept;
    logic [7:0][7:0]      report_in;

    assign s_tready  = !pend.valid || load;
    assign accept    = s_tvalid && s_tready;
    assign report_in = s_tdata[71:8];

    // command decode and state
    jbcr_cmd_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sel       (s_tuser),
        .rx_byte   (s_tdata[7:0]),
        .report_in (report_in),
        .load      (load),
        .pend      (pend)
    );

    // response sequencer
    jbcr_tx_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .pend     (pend),
        .load     (load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // link reset is always a single zero word
    a_reset_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[7:0] == 8'h00))
        else $error("link reset word malformed");

    // input only stalls behind a full pending slot
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (pend.valid && m_tvalid))
        else $error("input stalled without pending run");

    // a pending run is kept until the sequencer loads it
    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pend.valid && !load) |=> pend.valid)
        else $error("pending run lost");

endmodule
